// ===== src/eos_pkg.sv =====
`timescale 1ns / 1ps
package eos_pkg;

    // cordic start value, gain compensated, Q2.30
    localparam int CORDIC_GAIN = 652032874;
    // 1 / 2.618 in Q0.16
    localparam int INV_GOLD = 25033;
    // one in Q15.16, removed from the sum of squares
    localparam int F_BIAS = 65536;
    // magnitude limit of a scaled projection, Q16
    localparam int V_LIMIT = 16777216;
    // width of a clamped scaled projection
    localparam int V_W = 26;

    // configuration register indexes
    localparam logic [1:0] CFG_STOP_EARLY = 2'd0;
    localparam logic [1:0] CFG_TOLERANCE  = 2'd1;
    localparam logic [1:0] CFG_FIRST_STEP = 2'd2;
    localparam logic [1:0] CFG_ITER_CAP   = 2'd3;

    // arctan of 2^-i as a fraction of a 32-bit turn
    function automatic logic [29:0] atan_turn(input logic [4:0] idx);
        logic [29:0] r;
        begin
            unique case (idx)
                5'd0:  r = 30'd536870912;
                5'd1:  r = 30'd316933406;
                5'd2:  r = 30'd167458907;
                5'd3:  r = 30'd85004756;
                5'd4:  r = 30'd42667331;
                5'd5:  r = 30'd21354465;
                5'd6:  r = 30'd10679838;
                5'd7:  r = 30'd5340245;
                5'd8:  r = 30'd2670163;
                5'd9:  r = 30'd1335087;
                5'd10: r = 30'd667544;
                5'd11: r = 30'd333772;
                5'd12: r = 30'd166886;
                5'd13: r = 30'd83443;
                5'd14: r = 30'd41722;
                5'd15: r = 30'd20861;
                5'd16: r = 30'd10430;
                5'd17: r = 30'd5215;
                5'd18: r = 30'd2608;
                5'd19: r = 30'd1304;
                5'd20: r = 30'd652;
                5'd21: r = 30'd326;
                5'd22: r = 30'd163;
                5'd23: r = 30'd81;
                5'd24: r = 30'd41;
                5'd25: r = 30'd20;
                5'd26: r = 30'd10;
                5'd27: r = 30'd5;
                default: r = 30'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== src/eos_cordic.sv =====
`timescale 1ns / 1ps
module eos_cordic
    import eos_pkg::*;
#(
    parameter int ANGLE_BITS = 20,
    parameter int STEPS      = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [ANGLE_BITS-1:0] angle,
    output logic                  done,
    output logic signed [32:0]    cos_q30,
    output logic signed [32:0]    sin_q30
);

    logic signed [32:0] x_reg, x_next;
    logic signed [32:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic [4:0]         i_reg, i_next;
    logic               flip_reg, flip_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;

    logic [31:0]        z_turn;
    logic               flip_in;
    logic [31:0]        z_adj;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [33:0] at;

    // map to a 32-bit turn, fold the left half plane by half a turn
    assign z_turn  = {angle, {(32 - ANGLE_BITS){1'b0}}};
    assign flip_in = z_turn[31] ^ z_turn[30];
    assign z_adj   = {z_turn[31] ^ flip_in, z_turn[30:0]};

    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;
    assign at = 34'(atan_turn(i_reg));

    // one micro-rotation per cycle
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        flip_next = flip_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = 33'(CORDIC_GAIN);
            y_next    = '0;
            z_next    = 34'($signed(z_adj));
            i_next    = '0;
            flip_next = flip_in;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        i_reg    <= i_next;
        flip_reg <= flip_next;
    end

    assign done    = done_reg;
    assign cos_q30 = flip_reg ? -x_reg : x_reg;
    assign sin_q30 = flip_reg ? -y_reg : y_reg;

endmodule

// ===== src/eos_div.sv =====
`timescale 1ns / 1ps
module eos_div
    import eos_pkg::*;
#(
    parameter int NUM_W = 46,
    parameter int DEN_W = 23
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    done,
    output logic signed [V_W-1:0]   quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] mag_reg, mag_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [NUM_W-1:0] lim;
    logic [V_W-2:0]   qc;

    // restoring division on magnitudes, one quotient bit per cycle
    assign trial = {rem_reg, mag_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            mag_next = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            rem_next = '0;
            den_next = den;
            cnt_next = CNT_W'(NUM_W);
            neg_next = num[NUM_W-1];
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            mag_next = {mag_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    // clamp magnitude, restore sign (truncation toward zero)
    assign lim  = NUM_W'(V_LIMIT);
    assign qc   = (mag_reg > lim) ? (V_W - 1)'(V_LIMIT) : mag_reg[V_W-2:0];
    assign quo  = neg_reg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    assign done = done_reg;

endmodule

// ===== src/eos_surf.sv =====
`timescale 1ns / 1ps
module eos_surf
    import eos_pkg::*;
#(
    parameter int ANGLE_BITS   = 20,
    parameter int LENGTH_BITS  = 24,
    parameter int CORDIC_STEPS = 20
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ANGLE_BITS-1:0]         angle,
    input  logic signed [LENGTH_BITS-1:0] off_x,
    input  logic signed [LENGTH_BITS-1:0] off_y,
    input  logic [LENGTH_BITS-2:0]        own_ax,
    input  logic [LENGTH_BITS-2:0]        own_ay,
    input  logic signed [15:0]            own_c,
    input  logic signed [15:0]            own_s,
    input  logic [LENGTH_BITS-2:0]        oth_ax,
    input  logic [LENGTH_BITS-2:0]        oth_ay,
    input  logic signed [15:0]            oth_c,
    input  logic signed [15:0]            oth_s,
    output logic                          done,
    output logic signed [31:0]            f
);

    localparam int OPW   = (LENGTH_BITS + 3 > 34) ? LENGTH_BITS + 3 : 34;
    localparam int PW    = 2 * OPW;
    localparam int NUM_W = LENGTH_BITS + 22;
    localparam int CA_W  = LENGTH_BITS + 1;
    localparam int DR_W  = LENGTH_BITS + 3;
    localparam int AX_W  = LENGTH_BITS - 1;

    typedef enum logic [4:0] {
        S_IDLE, S_CORD, S_MCA, S_MSA, S_PX0, S_PX1, S_PY0, S_PY1, S_DY,
        S_D0A, S_D0B, S_D1A, S_D1B, S_DW0, S_DW1, S_SQ0, S_SQ1, S_SUM
    } state_t;

    state_t                   state_reg, state_next;
    logic signed [PW-1:0]     prod_reg, prod_next;
    logic signed [PW-1:0]     acc_reg, acc_next;
    logic signed [CA_W-1:0]   ca_reg, ca_next;
    logic signed [CA_W-1:0]   sa_reg, sa_next;
    logic signed [DR_W-1:0]   dx_reg, dx_next;
    logic signed [DR_W-1:0]   dy_reg, dy_next;
    logic signed [NUM_W-1:0]  num0_reg, num0_next;
    logic signed [NUM_W-1:0]  num1_reg, num1_next;
    logic signed [V_W-1:0]    v0_reg, v0_next;
    logic signed [V_W-1:0]    v1_reg, v1_next;
    logic signed [31:0]       f_reg, f_next;
    logic                     done_reg, done_next;

    logic signed [OPW-1:0]    op_a;
    logic signed [OPW-1:0]    op_b;
    logic                     cord_start;
    logic                     cord_done;
    logic signed [32:0]       co;
    logic signed [32:0]       si;
    logic                     div_start;
    logic signed [NUM_W-1:0]  div_num;
    logic                     div_done;
    logic signed [V_W-1:0]    div_quo;
    logic [AX_W-1:0]          bx;
    logic [AX_W-1:0]          by;
    logic [AX_W-1:0]          den;
    logic signed [PW-1:0]     sum;
    logic signed [PW-1:0]     f_wide;

    localparam logic signed [PW-1:0] F_MAX = PW'(64'sd2147483647);
    localparam logic signed [PW-1:0] F_MIN = -PW'(64'sd2147483648);

    // a zero axis of the second ellipse counts as one
    assign bx = (oth_ax == '0) ? AX_W'(1) : oth_ax;
    assign by = (oth_ay == '0) ? AX_W'(1) : oth_ay;

    assign cord_start = start && (state_reg == S_IDLE);

    eos_cordic #(
        .ANGLE_BITS (ANGLE_BITS),
        .STEPS      (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_start),
        .angle   (angle),
        .done    (cord_done),
        .cos_q30 (co),
        .sin_q30 (si)
    );

    assign div_num = (state_reg == S_D1B) ? num0_reg : num1_reg;
    assign den     = (state_reg == S_D1B) ? bx : by;

    eos_div #(
        .NUM_W (NUM_W),
        .DEN_W (AX_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // shared multiplier operand select
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            S_MCA: begin op_a = OPW'(co);     op_b = OPW'($signed({1'b0, own_ax})); end
            S_MSA: begin op_a = OPW'(si);     op_b = OPW'($signed({1'b0, own_ay})); end
            S_PX0: begin op_a = OPW'(ca_reg); op_b = OPW'(own_c); end
            S_PX1: begin op_a = OPW'(sa_reg); op_b = OPW'(own_s); end
            S_PY0: begin op_a = OPW'(ca_reg); op_b = OPW'(own_s); end
            S_PY1: begin op_a = OPW'(sa_reg); op_b = OPW'(own_c); end
            S_DY:  begin op_a = OPW'(dx_reg); op_b = OPW'(oth_c); end
            S_D0A: begin op_a = OPW'(dy_reg); op_b = OPW'(oth_s); end
            S_D0B: begin op_a = OPW'(dx_reg); op_b = OPW'(oth_s); end
            S_D1A: begin op_a = OPW'(dy_reg); op_b = OPW'(oth_c); end
            S_SQ0: begin op_a = OPW'(v0_reg); op_b = OPW'(v0_reg); end
            S_SQ1: begin op_a = OPW'(v1_reg); op_b = OPW'(v1_reg); end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign prod_next = op_a * op_b;
    assign sum       = acc_reg + prod_reg;
    assign f_wide    = (sum >>> 16) - PW'(F_BIAS);

    // evaluation sequencer
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        ca_next    = ca_reg;
        sa_next    = sa_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        num0_next  = num0_reg;
        num1_next  = num1_reg;
        v0_next    = v0_reg;
        v1_next    = v1_reg;
        f_next     = f_reg;
        done_next  = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_CORD;
            S_CORD: if (cord_done) state_next = S_MCA;
            S_MCA:  state_next = S_MSA;
            S_MSA:
            begin
                ca_next    = CA_W'(prod_reg >>> 30);
                state_next = S_PX0;
            end
            S_PX0:
            begin
                sa_next    = CA_W'(prod_reg >>> 30);
                state_next = S_PX1;
            end
            S_PX1:
            begin
                acc_next   = prod_reg;
                state_next = S_PY0;
            end
            S_PY0:
            begin
                dx_next    = DR_W'(((acc_reg - prod_reg) >>> 14) - PW'(off_x));
                state_next = S_PY1;
            end
            S_PY1:
            begin
                acc_next   = prod_reg;
                state_next = S_DY;
            end
            S_DY:
            begin
                dy_next    = DR_W'((sum >>> 14) - PW'(off_y));
                state_next = S_D0A;
            end
            S_D0A:
            begin
                acc_next   = prod_reg;
                state_next = S_D0B;
            end
            S_D0B:
            begin
                num0_next  = NUM_W'(sum <<< 2);
                state_next = S_D1A;
            end
            S_D1A:
            begin
                acc_next   = prod_reg;
                state_next = S_D1B;
            end
            S_D1B:
            begin
                num1_next  = NUM_W'((prod_reg - acc_reg) <<< 2);
                div_start  = 1'b1;
                state_next = S_DW0;
            end
            S_DW0:
            begin
                if (div_done)
                begin
                    v0_next    = div_quo;
                    div_start  = 1'b1;
                    state_next = S_DW1;
                end
            end
            S_DW1:
            begin
                if (div_done)
                begin
                    v1_next    = div_quo;
                    state_next = S_SQ0;
                end
            end
            S_SQ0:  state_next = S_SQ1;
            S_SQ1:
            begin
                acc_next   = prod_reg;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                priority if (f_wide > F_MAX)
                    f_next = 32'sh7fffffff;
                else if (f_wide < F_MIN)
                    f_next = 32'sh80000000;
                else
                    f_next = 32'(f_wide);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        ca_reg   <= ca_next;
        sa_reg   <= sa_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        num0_reg <= num0_next;
        num1_reg <= num1_next;
        v0_reg   <= v0_next;
        v1_reg   <= v1_next;
        f_reg    <= f_next;
    end

    assign done = done_reg;
    assign f    = f_reg;

endmodule

// ===== src/ellipse_overlap_search.sv =====
`timescale 1ns / 1ps
// Ellipse overlap search. Each input beat carries a pair of ellipses and a start
// angle; the block walks the boundary of the first ellipse looking for the angle
// where the second ellipse's implicit function is smallest (or, with stop_early
// set, the first point inside it), and returns one result beat. Every boundary
// evaluation runs on one shared sequencer: an iterative CORDIC, a shared
// multiplier and a serial divider used twice. An item takes one to
// max(iteration_cap, 3) evaluations. s_axis_tready is high only while no item
// is in progress; a finished result waits in the output register and the next
// item may be accepted meanwhile.
module ellipse_overlap_search
    import eos_pkg::*;
#(
    parameter int ANGLE_BITS   = 20,
    parameter int LENGTH_BITS  = 24,
    parameter int CORDIC_STEPS = 20
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // offset_x, offset_y, own_axis_x, own_axis_y, own_cos, own_sin,
    // other_axis_x, other_axis_y, other_cos, other_sin, start_angle
    input  logic [223:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // found_angle, surface_value, is_overlap, cap_reached, 2 bits zero
    output logic [55:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [18:0]  cfg_data
);

    // search positions drift by at most max(iteration_cap, 3) times first_step
    localparam int AW   = 40;
    localparam int AX_W = LENGTH_BITS - 1;

    typedef enum logic [2:0] {
        S_IDLE, S_PROBE, S_WAIT, S_LOOP, S_NARROW, S_DONE
    } state_t;

    typedef enum logic [2:0] {
        T_B, T_A, T_C, T_PRE, T_R, T_L, T_N
    } tag_t;

    // configuration
    logic        stop_reg;
    logic [15:0] tol_reg;
    logic [18:0] step_reg;
    logic [15:0] cap_reg;

    // item
    logic signed [LENGTH_BITS-1:0] offx_reg, offy_reg;
    logic [AX_W-1:0]               oax_reg, oay_reg, tax_reg, tay_reg;
    logic signed [15:0]            oc_reg, os_reg, tc_reg, ts_reg;

    // search
    state_t               state_reg, state_next;
    tag_t                 tag_reg, tag_next;
    logic signed [AW-1:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic signed [AW-1:0] pa_reg, pa_next;
    logic signed [31:0]   fa_reg, fa_next, fb_reg, fb_next, fc_reg, fc_next;
    logic [18:0]          d_reg, d_next;
    logic [15:0]          cnt_reg, cnt_next;
    logic signed [AW-1:0] res_ang_reg, res_ang_next;
    logic signed [31:0]   res_f_reg, res_f_next;
    logic                 res_cap_reg, res_cap_next;
    logic                 out_valid_reg, out_valid_next;
    logic [19:0]          out_ang_reg, out_ang_next;
    logic signed [31:0]   out_f_reg, out_f_next;
    logic                 out_cap_reg, out_cap_next;

    logic                  in_fire;
    logic [ANGLE_BITS-1:0] start_turn;
    logic signed [AW-1:0]  d_ext;
    logic signed [AW-1:0]  tol_ext;
    logic signed [AW-1:0]  diff;
    logic [34:0]           nprod;
    logic                  refused;
    logic                  surf_start;
    logic                  surf_done;
    logic signed [31:0]    surf_f;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign start_turn    = ANGLE_BITS'(s_axis_tdata[223:204]);
    assign d_ext         = AW'(d_reg);
    assign tol_ext       = AW'(tol_reg);
    assign diff          = c_reg - b_reg;
    assign nprod         = diff[19:0] * 35'(INV_GOLD);
    assign refused       = (cnt_reg >= 16'd3) && (cnt_reg >= cap_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg <= 1'b1;
            tol_reg  <= 16'd17;
            step_reg <= 19'd52429;
            cap_reg  <= 16'd1024;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STOP_EARLY: stop_reg <= cfg_data[0];
                CFG_TOLERANCE:  tol_reg  <= cfg_data[15:0];
                CFG_FIRST_STEP: step_reg <= cfg_data;
                CFG_ITER_CAP:   cap_reg  <= cfg_data[15:0];
                default:        stop_reg <= stop_reg;
            endcase
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            offx_reg <= LENGTH_BITS'(s_axis_tdata[23:0]);
            offy_reg <= LENGTH_BITS'(s_axis_tdata[47:24]);
            oax_reg  <= AX_W'(s_axis_tdata[70:48]);
            oay_reg  <= AX_W'(s_axis_tdata[93:71]);
            oc_reg   <= s_axis_tdata[109:94];
            os_reg   <= s_axis_tdata[125:110];
            tax_reg  <= AX_W'(s_axis_tdata[148:126]);
            tay_reg  <= AX_W'(s_axis_tdata[171:149]);
            tc_reg   <= s_axis_tdata[187:172];
            ts_reg   <= s_axis_tdata[203:188];
        end
    end

    eos_surf #(
        .ANGLE_BITS   (ANGLE_BITS),
        .LENGTH_BITS  (LENGTH_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_surf (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (surf_start),
        .angle  (pa_reg[ANGLE_BITS-1:0]),
        .off_x  (offx_reg),
        .off_y  (offy_reg),
        .own_ax (oax_reg),
        .own_ay (oay_reg),
        .own_c  (oc_reg),
        .own_s  (os_reg),
        .oth_ax (tax_reg),
        .oth_ay (tay_reg),
        .oth_c  (tc_reg),
        .oth_s  (ts_reg),
        .done   (surf_done),
        .f      (surf_f)
    );

    // search sequencer
    always_comb
    begin
        state_next     = state_reg;
        tag_next       = tag_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        pa_next        = pa_reg;
        fa_next        = fa_reg;
        fb_next        = fb_reg;
        fc_next        = fc_reg;
        d_next         = d_reg;
        cnt_next       = cnt_reg;
        res_ang_next   = res_ang_reg;
        res_f_next     = res_f_reg;
        res_cap_next   = res_cap_reg;
        out_valid_next = out_valid_reg;
        out_ang_next   = out_ang_reg;
        out_f_next     = out_f_reg;
        out_cap_next   = out_cap_reg;
        surf_start     = 1'b0;

        if (m_axis_tvalid && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    b_next     = AW'(start_turn);
                    a_next     = AW'(start_turn) - AW'(step_reg);
                    c_next     = AW'(start_turn) + AW'(step_reg);
                    d_next     = step_reg;
                    cnt_next   = '0;
                    pa_next    = AW'(start_turn);
                    tag_next   = T_B;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (refused)
                begin
                    res_ang_next = b_reg;
                    res_f_next   = fb_reg;
                    res_cap_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 16'd1;
                    surf_start = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (surf_done)
                begin
                    if (stop_reg && surf_f[31])
                    begin
                        res_ang_next = pa_reg;
                        res_f_next   = surf_f;
                        res_cap_next = 1'b0;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        unique case (tag_reg)
                            T_B:
                            begin
                                fb_next    = surf_f;
                                pa_next    = a_reg;
                                tag_next   = T_A;
                                state_next = S_PROBE;
                            end
                            T_A:
                            begin
                                fa_next    = surf_f;
                                pa_next    = c_reg;
                                tag_next   = T_C;
                                state_next = S_PROBE;
                            end
                            T_C:
                            begin
                                fc_next    = surf_f;
                                state_next = S_LOOP;
                                if (fa_reg < fb_reg && surf_f < fb_reg)
                                begin
                                    c_next     = b_reg;
                                    fc_next    = fb_reg;
                                    b_next     = a_reg;
                                    fb_next    = fa_reg;
                                    a_next     = a_reg - d_ext;
                                    pa_next    = a_reg - d_ext;
                                    tag_next   = T_PRE;
                                    state_next = S_PROBE;
                                end
                            end
                            T_PRE:
                            begin
                                fa_next    = surf_f;
                                state_next = S_LOOP;
                            end
                            T_R:
                            begin
                                fc_next = surf_f;
                                if (fb_reg > surf_f)
                                begin
                                    a_next     = b_reg;
                                    fa_next    = fb_reg;
                                    b_next     = c_reg;
                                    fb_next    = surf_f;
                                    c_next     = c_reg + d_ext;
                                    pa_next    = c_reg + d_ext;
                                    state_next = S_PROBE;
                                end
                                else
                                begin
                                    d_next     = d_reg >> 1;
                                    state_next = S_LOOP;
                                end
                            end
                            T_L:
                            begin
                                fa_next = surf_f;
                                if (surf_f < fc_reg)
                                begin
                                    c_next     = b_reg;
                                    fc_next    = fb_reg;
                                    b_next     = a_reg;
                                    fb_next    = surf_f;
                                    a_next     = a_reg - d_ext;
                                    pa_next    = a_reg - d_ext;
                                    state_next = S_PROBE;
                                end
                                else
                                begin
                                    d_next     = d_reg >> 1;
                                    state_next = S_LOOP;
                                end
                            end
                            T_N:
                            begin
                                if (surf_f > fb_reg)
                                begin
                                    c_next  = pa_reg;
                                    fc_next = surf_f;
                                end
                                else
                                begin
                                    b_next  = pa_reg;
                                    fb_next = surf_f;
                                end
                                state_next = S_NARROW;
                            end
                            default: state_next = S_NARROW;
                        endcase
                    end
                end
            end
            S_LOOP:
            begin
                priority if (fa_reg > fb_reg && fc_reg > fb_reg)
                    state_next = S_NARROW;
                else if (fa_reg > fb_reg && fb_reg > fc_reg)
                begin
                    // walk right
                    a_next     = b_reg;
                    fa_next    = fb_reg;
                    b_next     = c_reg;
                    fb_next    = fc_reg;
                    c_next     = c_reg + d_ext;
                    pa_next    = c_reg + d_ext;
                    tag_next   = T_R;
                    state_next = S_PROBE;
                end
                else if (fa_reg < fb_reg && fb_reg < fc_reg)
                begin
                    // walk left
                    c_next     = b_reg;
                    fc_next    = fb_reg;
                    b_next     = a_reg;
                    fb_next    = fa_reg;
                    a_next     = a_reg - d_ext;
                    pa_next    = a_reg - d_ext;
                    tag_next   = T_L;
                    state_next = S_PROBE;
                end
                else
                    state_next = S_NARROW;
            end
            S_NARROW:
            begin
                if (diff > tol_ext)
                begin
                    pa_next    = b_reg + AW'(nprod[34:16]);
                    tag_next   = T_N;
                    state_next = S_PROBE;
                end
                else
                begin
                    res_ang_next = b_reg;
                    res_f_next   = fb_reg;
                    res_cap_next = 1'b0;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_ang_next   = 20'(res_ang_reg[ANGLE_BITS-1:0]);
                    out_f_next     = res_f_reg;
                    out_cap_next   = res_cap_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tag_reg       <= T_B;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            res_cap_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tag_reg       <= tag_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            res_cap_reg   <= res_cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        c_reg       <= c_next;
        pa_reg      <= pa_next;
        fa_reg      <= fa_next;
        fb_reg      <= fb_next;
        fc_reg      <= fc_next;
        d_reg       <= d_next;
        res_ang_reg <= res_ang_next;
        res_f_reg   <= res_f_next;
        out_ang_reg <= out_ang_next;
        out_f_reg   <= out_f_next;
        out_cap_reg <= out_cap_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_cap_reg, out_f_reg[31], out_f_reg, out_ang_reg};

    // narrowing keeps the bracket ordered
    ap_bracket_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_NARROW |-> c_reg >= b_reg)
        else $error("bracket end below its best point");

    // a capped result only after the evaluation budget is used up
    ap_cap_budget: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && res_cap_reg |-> cnt_reg >= 16'd3 && cnt_reg >= cap_reg)
        else $error("cap flagged with evaluations left");

    // evaluation results only arrive while the search waits for one
    ap_eval_owner: assert property (@(posedge clk) disable iff (!rst_n)
        surf_done |-> state_reg == S_WAIT)
        else $error("evaluation finished outside wait");

    // overlap flag follows the value sign
    ap_overlap_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[52] == m_axis_tdata[51])
        else $error("overlap flag disagrees with value");

endmodule

// ===== verif/ellipse_overlap_search_tb.sv =====
`timescale 1ns / 1ps
module ellipse_overlap_search_tb;
    import eos_pkg::*;

    typedef struct packed {
        logic [19:0] start_angle;
        logic [15:0] other_sin;
        logic [15:0] other_cos;
        logic [22:0] other_axis_y;
        logic [22:0] other_axis_x;
        logic [15:0] own_sin;
        logic [15:0] own_cos;
        logic [22:0] own_axis_y;
        logic [22:0] own_axis_x;
        logic [23:0] offset_y;
        logic [23:0] offset_x;
    } pair_t;

    typedef struct {
        logic [19:0] found_angle;
        logic [31:0] surface_value;
        logic        is_overlap;
        logic        cap_reached;
    } hit_t;

    // arctan of 2^-i in 32-bit turn units
    localparam longint ARC [0:19] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
        5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304
    };

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // offset_x, offset_y, own_axis_x, own_axis_y, own_cos, own_sin,
    // other_axis_x, other_axis_y, other_cos, other_sin, start_angle
    logic [223:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // found_angle, surface_value, is_overlap, cap_reached, 2 bits zero
    logic [55:0]  m_axis_tdata;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [18:0]  cfg_data;

    ellipse_overlap_search dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // model copy of the registers
    logic        stop_early_q;
    logic [15:0] tolerance_q;
    logic [18:0] first_step_q;
    logic [15:0] iter_cap_q;

    // geometry of the item being predicted
    longint off_v [2];
    longint own_ax [2];
    longint own_dir [2];
    longint oth_ax [2];
    longint oth_dir [2];
    longint probes_done;

    pair_t  pending_pairs [$];
    hit_t   expected_hits [$];
    int     pairs_queued;
    int     hits_seen;
    int     fails;
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     recv_hold;
    bit     send_hold;
    bit     beat_taken;

    task automatic report(input string what);
        $display("mismatch: %s", what);
        fails++;
    endtask

    // rotation-mode cordic, cos and sin in Q2.30
    function automatic void boundary_sincos(input longint ang, output longint co,
                                            output longint si);
        logic [31:0] z;
        logic        flip;
        longint      zz, x, y, dx, dy;
        z = {ang[19:0], 12'd0};
        flip = (z[31:30] == 2'd1) || (z[31:30] == 2'd2);
        if (flip)
            z = z + 32'h8000_0000;
        zz = $signed(z);
        x = CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < 20; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (zz >= 0)
            begin
                x -= dx; y += dy; zz -= ARC[i];
            end
            else
            begin
                x += dx; y -= dy; zz += ARC[i];
            end
        end
        co = flip ? -x : x;
        si = flip ? -y : y;
    endfunction

    function automatic longint clamp_proj(input longint v);
        if (v > V_LIMIT)
            return V_LIMIT;
        if (v < -V_LIMIT)
            return -V_LIMIT;
        return v;
    endfunction

    // implicit function of the second ellipse at a boundary angle
    function automatic int surface_at(input longint ang);
        longint co, si, ca, sa, px, py, dx, dy, d0, d1, v0, v1, f, bx, by;
        bx = oth_ax[0] != 0 ? oth_ax[0] : 1;
        by = oth_ax[1] != 0 ? oth_ax[1] : 1;
        boundary_sincos(ang, co, si);
        ca = (co * own_ax[0]) >>> 30;
        sa = (si * own_ax[1]) >>> 30;
        px = (ca * own_dir[0] - sa * own_dir[1]) >>> 14;
        py = (ca * own_dir[1] + sa * own_dir[0]) >>> 14;
        dx = px - off_v[0];
        dy = py - off_v[1];
        d0 = dx * oth_dir[0] + dy * oth_dir[1];
        d1 = -dx * oth_dir[1] + dy * oth_dir[0];
        v0 = clamp_proj((d0 * 4) / bx);
        v1 = clamp_proj((d1 * 4) / by);
        f = ((v0 * v0 + v1 * v1) >> 16) - F_BIAS;
        if (f > 64'sd2147483647)
            f = 64'sd2147483647;
        if (f < -64'sd2147483648)
            f = -64'sd2147483648;
        return int'(f);
    endfunction

    // 0 evaluated, 1 negative with early exit, 2 refused by the cap
    function automatic int take_probe(input longint ang, output int f);
        if (probes_done >= 3 && probes_done >= iter_cap_q)
            return 2;
        probes_done++;
        f = surface_at(ang);
        if (stop_early_q && f < 0)
            return 1;
        return 0;
    endfunction

    // bracket then narrow; returns 1 when the cap ended the search
    function automatic bit search_minimum(input longint start, output longint ang,
                                          output int val);
        longint d, a, b, c, y;
        int     fa, fb, fc, fy, st;
        d = first_step_q; a = start - d; b = start; c = start + d;
        fa = 0; fb = 0; fc = 0; fy = 0;
        if (take_probe(b, fb) == 1) begin ang = b; val = fb; return 0; end
        if (take_probe(a, fa) == 1) begin ang = a; val = fa; return 0; end
        if (take_probe(c, fc) == 1) begin ang = c; val = fc; return 0; end
        if (fa < fb && fc < fb)
        begin
            c = b; fc = fb; b = a; fb = fa; a -= d;
            st = take_probe(a, fa);
            if (st == 1) begin ang = a; val = fa; return 0; end
            if (st == 2) begin ang = b; val = fb; return 1; end
        end
        while (!(fa > fb && fc > fb))
        begin
            if (fa > fb && fb > fc)
            begin
                do
                begin
                    a = b; fa = fb; b = c; fb = fc; c += d;
                    st = take_probe(c, fc);
                    if (st == 1) begin ang = c; val = fc; return 0; end
                    if (st == 2) begin ang = b; val = fb; return 1; end
                end while (fb > fc);
            end
            else if (fa < fb && fb < fc)
            begin
                do
                begin
                    c = b; fc = fb; b = a; fb = fa; a -= d;
                    st = take_probe(a, fa);
                    if (st == 1) begin ang = a; val = fa; return 0; end
                    if (st == 2) begin ang = b; val = fb; return 1; end
                end while (fa < fc);
            end
            else
                break;
            d = d / 2;
        end
        while (c - b > tolerance_q)
        begin
            y = b + (((c - b) * INV_GOLD) >> 16);
            st = take_probe(y, fy);
            if (st == 1) begin ang = y; val = fy; return 0; end
            if (st == 2) begin ang = b; val = fb; return 1; end
            if (fy > fb)
            begin
                c = y; fc = fy;
            end
            else
            begin
                a = b; fa = fb; b = y; fb = fy;
            end
        end
        ang = b; val = fb;
        return 0;
    endfunction

    function automatic hit_t predict_hit(input pair_t p);
        hit_t   h;
        longint ang;
        int     val;
        off_v[0] = $signed(p.offset_x);
        off_v[1] = $signed(p.offset_y);
        own_ax[0] = p.own_axis_x;
        own_ax[1] = p.own_axis_y;
        own_dir[0] = $signed(p.own_cos);
        own_dir[1] = $signed(p.own_sin);
        oth_ax[0] = p.other_axis_x;
        oth_ax[1] = p.other_axis_y;
        oth_dir[0] = $signed(p.other_cos);
        oth_dir[1] = $signed(p.other_sin);
        probes_done = 0;
        h.cap_reached = search_minimum(longint'(p.start_angle), ang, val);
        h.found_angle = ang[19:0];
        h.surface_value = val;
        h.is_overlap = val < 0;
        return h;
    endfunction

    // well-formed pair: unit directions, moderate sizes, centers close by
    function automatic pair_t shaped_pair();
        pair_t p;
        real   t0, t1;
        int    span;
        t0 = $urandom_range(0, 6283) / 1000.0;
        t1 = $urandom_range(0, 6283) / 1000.0;
        span = $urandom_range(1, 3) == 1 ? 500000 : 100000;
        p.offset_x = 24'($urandom_range(0, 2 * span) - span);
        p.offset_y = 24'($urandom_range(0, 2 * span) - span);
        p.own_axis_x = 23'($urandom_range(1024, 131072));
        p.own_axis_y = 23'($urandom_range(1024, 131072));
        p.own_cos = 16'(int'($cos(t0) * 16384.0));
        p.own_sin = 16'(int'($sin(t0) * 16384.0));
        p.other_axis_x = 23'($urandom_range(1024, 131072));
        p.other_axis_y = 23'($urandom_range(1024, 131072));
        p.other_cos = 16'(int'($cos(t1) * 16384.0));
        p.other_sin = 16'(int'($sin(t1) * 16384.0));
        p.start_angle = 20'($urandom);
        return p;
    endfunction

    function automatic pair_t noise_pair();
        pair_t p;
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return p;
    endfunction

    task automatic cfg_write(input logic [1:0] idx, input logic [18:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_STOP_EARLY: stop_early_q = val[0];
            CFG_TOLERANCE:  tolerance_q = val[15:0];
            CFG_FIRST_STEP: first_step_q = val;
            CFG_ITER_CAP:   iter_cap_q = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input bit se, input int tol, input int step, input int cap);
        cfg_write(CFG_STOP_EARLY, 19'(se));
        cfg_write(CFG_TOLERANCE, 19'(tol));
        cfg_write(CFG_FIRST_STEP, 19'(step));
        cfg_write(CFG_ITER_CAP, 19'(cap));
    endtask

    // wait until every queued pair has its result, then let the block settle
    task automatic drain();
        while (pairs_queued != hits_seen || pending_pairs.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic queue_pair(input pair_t p);
        pending_pairs.push_back(p);
        pairs_queued++;
    endtask

    task automatic random_run(input int n);
        for (int i = 0; i < n; i++)
            queue_pair($urandom_range(0, 9) < 7 ? shaped_pair() : noise_pair());
        drain();
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #400_000_000;
        $display("tb: failure");
        $finish;
    end

    // input beat driver
    always @(negedge clk)
    begin
        if (!s_axis_tvalid || beat_taken)
        begin
            if (pending_pairs.size() != 0 && !send_hold
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_pairs.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result ready driver
    always @(negedge clk)
    begin
        m_axis_tready <= !recv_hold && $urandom_range(0, 99) >= recv_idle_pct;
    end

    // accept beats, predict and check results
    always @(posedge clk)
    begin
        hit_t want;
        beat_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_hits.push_back(predict_hit(pair_t'(s_axis_tdata)));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            hits_seen++;
            if (expected_hits.size() == 0)
                report("result beat with nothing expected");
            else
            begin
                want = expected_hits.pop_front();
                if (m_axis_tdata[19:0] !== want.found_angle)
                    report($sformatf("found_angle %0d want %0d",
                                     m_axis_tdata[19:0], want.found_angle));
                if (m_axis_tdata[51:20] !== want.surface_value)
                    report($sformatf("surface_value %0d want %0d",
                                     $signed(m_axis_tdata[51:20]),
                                     $signed(want.surface_value)));
                if (m_axis_tdata[52] !== want.is_overlap)
                    report($sformatf("is_overlap %b want %b",
                                     m_axis_tdata[52], want.is_overlap));
                if (m_axis_tdata[53] !== want.cap_reached)
                    report($sformatf("cap_reached %b want %b",
                                     m_axis_tdata[53], want.cap_reached));
            end
        end
    end

    // stimulus
    initial
    begin
        pair_t p;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_STOP_EARLY;
        cfg_data = '0;
        beat_taken = 1'b0;
        recv_hold = 1'b0;
        send_hold = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        pairs_queued = 0;
        hits_seen = 0;
        fails = 0;
        stop_early_q = 1'b1;
        tolerance_q = 16'd17;
        first_step_q = 19'd52429;
        iter_cap_q = 16'd1024;
        rst_n = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // reset values: a probe inside a wide second ellipse stops at once
        p = shaped_pair();
        p.offset_x = '0; p.offset_y = '0;
        p.other_axis_x = 23'h7FFFFF; p.other_axis_y = 23'h7FFFFF;
        queue_pair(p);
        drain();

        // largest cap, early exit keeps it short
        set_regs(1'b1, 17, 52429, 65535);
        queue_pair(p);
        p.start_angle = 20'hFFFFF;
        queue_pair(p);
        drain();

        // field extremes, plain minimization
        set_regs(1'b0, 17, 52429, 40);
        p = shaped_pair();
        p.offset_x = 24'h800000; p.offset_y = 24'h7FFFFF; p.start_angle = '0;
        queue_pair(p);
        p.offset_x = 24'h7FFFFF; p.offset_y = 24'h800000; p.start_angle = 20'hFFFFF;
        queue_pair(p);
        p = shaped_pair();
        p.own_axis_x = 23'd1; p.own_axis_y = 23'h7FFFFF;
        p.other_axis_x = 23'h7FFFFF; p.other_axis_y = 23'd1;
        queue_pair(p);
        // zero axes of the second ellipse
        p.other_axis_x = '0; p.other_axis_y = '0;
        queue_pair(p);
        p = shaped_pair();
        p.own_cos = 16'sd16384; p.own_sin = '0;
        p.other_cos = '0; p.other_sin = -16'sd16384;
        queue_pair(p);
        p.own_cos = -16'sd16384; p.other_sin = 16'sd16384;
        p.offset_x = '0; p.offset_y = '0;
        queue_pair(p);
        queue_pair(noise_pair());
        queue_pair({224{1'b1}});
        drain();

        // cap below three, then a worn-out step, then a huge step
        set_regs(1'b0, 1, 1, 1);
        queue_pair(shaped_pair());
        queue_pair(shaped_pair());
        drain();
        set_regs(1'b0, 1, 2, 60);
        queue_pair(shaped_pair());
        drain();
        set_regs(1'b0, 65535, 524287, 20);
        queue_pair(shaped_pair());
        queue_pair(shaped_pair());
        drain();

        // hold results back while the sender keeps offering
        set_regs(1'b1, 200, 30000, 12);
        recv_hold = 1'b1;
        for (int i = 0; i < 6; i++)
            queue_pair(shaped_pair());
        repeat (20000) @(negedge clk);
        recv_hold = 1'b0;
        // sender pauses until every accepted beat has its result
        send_hold = 1'b1;
        while (expected_hits.size() != 0)
            @(negedge clk);
        send_hold = 1'b0;
        drain();

        send_idle_pct = 13;
        recv_idle_pct = 84;
        set_regs(1'b1, $urandom_range(1, 2000), $urandom_range(1, 262144),
                 $urandom_range(3, 40));
        random_run(90);

        send_idle_pct = 84;
        recv_idle_pct = 13;
        set_regs(1'b0, $urandom_range(1, 2000), $urandom_range(1000, 262144),
                 $urandom_range(3, 40));
        random_run(90);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs($urandom_range(0, 1), $urandom_range(1, 65535),
                 $urandom_range(1, 262144), $urandom_range(1, 40));
        random_run(50);
        set_regs($urandom_range(0, 1), $urandom_range(1, 500),
                 $urandom_range(1, 524287), $urandom_range(3, 40));
        random_run(50);

        repeat (200) @(negedge clk);
        if (fails == 0 && expected_hits.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
